[src/assert_macros.svh]
// Assertion macros for the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define CHK_NOW(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define CHK_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

[src/mptu_pkg.sv]
// Package: constants, codes and types of the proportional tracker
`default_nettype none
package mptu_pkg;
    localparam int NUM_CHANNELS = 4;
    localparam int CH_W = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_GOAL  = 2'd1;
    localparam logic [1:0] REQ_STATE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXAC = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EPS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN0 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN1 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN2 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN3 = 3'd7;

    // 360 and 180 degrees in Q16.16, plus a multiple of 360 that lifts any
    // 33-bit signed value above zero
    localparam logic [33:0] DEG360   = 34'd23592960;
    localparam logic [33:0] DEG180   = 34'd11796480;
    localparam logic [33:0] WRAP_OFS = 34'd6039797760;
    localparam logic [3:0]  WRAP_TOP = 4'd8;

    typedef struct packed {
        logic [20:0] step_size;
        logic [20:0] max_accum;
        logic [15:0] epsilon;
        logic [3:0]  angle_mask;
        logic [NUM_CHANNELS-1:0][15:0] gain;
    } cfg_t;
endpackage
`default_nettype wire

[src/mptu_if.sv]
// Channel interfaces: request, result and configuration write
`default_nettype none
interface mptu_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [1:0]  channel;
    logic signed [31:0] value;
    logic signed [31:0] dt;
    modport source (output valid, req_type, channel, value, dt, input ready);
    modport sink (input valid, req_type, channel, value, dt, output ready);
endinterface

interface mptu_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  out_channel;
    logic signed [31:0] state_value;
    logic        goal_reached;
    logic        last;
    modport source (output valid, out_channel, state_value, goal_reached, last,
                    input ready);
    modport sink (input valid, out_channel, state_value, goal_reached, last,
                  output ready);
endinterface

interface mptu_cfg_if;
    logic        valid;
    logic        ready;
    logic [mptu_pkg::CFG_IDX_W-1:0]  index;
    logic [mptu_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[src/mptu_cfg.sv]
// Configuration register file
`default_nettype none
module mptu_cfg (
    input  wire logic      clk,
    input  wire logic      rst_n,
    mptu_cfg_if.sink       cfg,
    output mptu_pkg::cfg_t regs
);
    mptu_pkg::cfg_t regs_reg;
    logic [mptu_pkg::CH_W-1:0] gidx;

    assign cfg.ready = 1'b1;
    assign regs = regs_reg;
    assign gidx = mptu_pkg::CH_W'(cfg.index - mptu_pkg::CFG_GAIN0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.step_size  <= 21'd1092;
            regs_reg.max_accum  <= 21'd6554;
            regs_reg.epsilon    <= 16'd1;
            regs_reg.angle_mask <= 4'd0;
            for (int i = 0; i < mptu_pkg::NUM_CHANNELS; i++)
            begin
                regs_reg.gain[i] <= 16'd256;
            end
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                mptu_pkg::CFG_STEP:  regs_reg.step_size  <= cfg.data[20:0];
                mptu_pkg::CFG_MAXAC: regs_reg.max_accum  <= cfg.data[20:0];
                mptu_pkg::CFG_EPS:   regs_reg.epsilon    <= cfg.data[15:0];
                mptu_pkg::CFG_ANGLE: regs_reg.angle_mask <= cfg.data[3:0];
                mptu_pkg::CFG_GAIN0, mptu_pkg::CFG_GAIN1,
                mptu_pkg::CFG_GAIN2, mptu_pkg::CFG_GAIN3:
                begin
                    if ({1'b0, gidx} < (mptu_pkg::CH_W + 1)'(mptu_pkg::NUM_CHANNELS))
                    begin
                        regs_reg.gain[gidx] <= cfg.data[15:0];
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

[src/multichannel_proportional_tracker_unit.sv]
// Top level: multichannel proportional tracker with goal/state memories
// Set goal / set state: written on acceptance, no result; one transaction at a time.
// Tick, dt >= 0: S substeps after acceptance, each running a snap, linear or angle step
//   per channel (9-step modulo-360 sequencer, error and state).
// Then one result per channel (read, load, wait for ready); a negative dt goes straight there.
// Reset: asynchronous, active low; a clearing pass over every channel zeroes the memories.
`default_nettype none
module multichannel_proportional_tracker_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    mptu_cfg_if.sink  cfg,
    mptu_in_if.sink   req,
    mptu_out_if.source rsp
);
    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_CHECK, S_RD, S_ERR, S_WRAP, S_MAG, S_MUL, S_PSAT,
        S_MULL, S_MULH, S_SUM, S_WRITE, S_NEXT, S_OUT_RD, S_OUT_LD, S_OUT_WAIT
    } st_t;

    mptu_pkg::cfg_t regs;

    st_t  st_reg;
    logic [mptu_pkg::CH_W-1:0] ch_reg;
    logic [20:0] accum_reg;
    logic        flag_reg;
    logic        wrap_ns_reg;
    logic [3:0]  k_reg;
    logic [33:0] mod_reg;
    logic signed [32:0] err_reg;
    logic signed [31:0] cur_reg;
    logic signed [31:0] gl_reg;
    logic signed [31:0] ns_reg;
    logic signed [49:0] prod_reg;
    logic signed [41:0] p_reg;
    logic [44:0] lo_reg;
    logic signed [39:0] hi_reg;
    logic        out_valid_reg;
    logic [mptu_pkg::CH_W-1:0] out_ch_reg;
    logic signed [31:0] out_val_reg;
    logic        out_last_reg;

    logic signed [31:0] goal_mem [mptu_pkg::NUM_CHANNELS];
    logic signed [31:0] state_mem [mptu_pkg::NUM_CHANNELS];
    logic signed [31:0] goal_rd_reg;
    logic signed [31:0] state_rd_reg;

    logic in_acc;
    logic ch_ok;
    logic ang;
    logic last_ch;
    logic goal_we, state_we;
    logic [mptu_pkg::CH_W-1:0] wr_addr;
    logic signed [31:0] goal_wd, state_wd;
    logic [32:0] acc_sum;
    logic [20:0] acc_clamped;
    logic signed [32:0] diff;
    logic [33:0] mod_step, mod_new;
    logic [32:0] mag;
    logic moving;
    logic signed [41:0] p_sh;
    logic signed [63:0] total;
    logic signed [47:0] d;
    logic signed [48:0] ns_w;
    logic signed [31:0] ns_sat;

    function automatic logic [33:0] DEG360_SH(input logic [3:0] k);
        DEG360_SH = mptu_pkg::DEG360 << k;
    endfunction

    mptu_cfg u_cfg (.clk(clk), .rst_n(rst_n), .cfg(cfg), .regs(regs));

    assign in_acc  = req.valid && req.ready;
    assign req.ready = (st_reg == S_IDLE);
    assign ch_ok   = {1'b0, req.channel} < (mptu_pkg::CH_W + 1)'(mptu_pkg::NUM_CHANNELS);
    assign ang     = regs.angle_mask[ch_reg];
    assign last_ch = ({1'b0, ch_reg} == (mptu_pkg::CH_W + 1)'(mptu_pkg::NUM_CHANNELS - 1));

    assign rsp.valid        = out_valid_reg;
    assign rsp.out_channel  = out_ch_reg;
    assign rsp.state_value  = out_val_reg;
    assign rsp.goal_reached = flag_reg;
    assign rsp.last         = out_last_reg;

    // memory write port: clearing pass, host writes, substep results
    always_comb
    begin
        goal_we  = 1'b0;
        state_we = 1'b0;
        wr_addr  = ch_reg;
        goal_wd  = req.value;
        state_wd = req.value;
        case (st_reg)
            S_CLR:
            begin
                goal_we  = 1'b1;
                state_we = 1'b1;
                goal_wd  = '0;
                state_wd = '0;
            end
            S_IDLE:
            begin
                wr_addr  = req.channel;
                goal_we  = in_acc && ch_ok && (req.req_type == mptu_pkg::REQ_GOAL);
                state_we = in_acc && ch_ok && (req.req_type == mptu_pkg::REQ_STATE);
            end
            S_MAG:
            begin
                state_we = !moving;
                state_wd = gl_reg;
            end
            S_WRITE:
            begin
                state_we = 1'b1;
                state_wd = ns_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (goal_we)
        begin
            goal_mem[wr_addr] <= goal_wd;
        end
        if (state_we)
        begin
            state_mem[wr_addr] <= state_wd;
        end
        goal_rd_reg  <= goal_mem[ch_reg];
        state_rd_reg <= state_mem[ch_reg];
    end

    assign acc_sum     = {12'd0, accum_reg} + {1'b0, req.dt};
    assign acc_clamped = (acc_sum > {12'd0, regs.max_accum}) ? regs.max_accum : acc_sum[20:0];
    assign diff        = {state_rd_reg[31], state_rd_reg} - {goal_rd_reg[31], goal_rd_reg};

    // one restoring step of the modulo-360 reduction
    assign mod_step = DEG360_SH(k_reg);
    assign mod_new  = (mod_reg >= mod_step) ? (mod_reg - mod_step) : mod_reg;

    assign mag    = err_reg[32] ? 33'(-err_reg) : 33'(err_reg);
    assign moving = mag > {17'd0, regs.epsilon};

    // floor shift; S_PSAT then clamps it to +-2^40
    assign p_sh = 42'(prod_reg >>> 8);

    assign total  = $signed({{2{hi_reg[39]}}, hi_reg, 22'd0} <<< 2)
                  + $signed({19'd0, lo_reg});
    assign d      = 48'(total >>> 16);
    assign ns_w   = 49'(cur_reg) - 49'(d);
    assign ns_sat = (ns_w > 49'sd2147483647) ? 32'sh7fffffff :
                    (ns_w < -49'sd2147483648) ? 32'sh80000000 : ns_w[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_CLR;
            ch_reg        <= '0;
            accum_reg     <= '0;
            flag_reg      <= 1'b0;
            wrap_ns_reg   <= 1'b0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            out_ch_reg    <= '0;
        end
        else
        begin
            unique case (st_reg)
                S_CLR:
                begin
                    if (last_ch)
                    begin
                        ch_reg <= '0;
                        st_reg <= S_IDLE;
                    end
                    else
                    begin
                        ch_reg <= ch_reg + 1'b1;
                    end
                end
                S_IDLE:
                begin
                    if (in_acc && req.req_type == mptu_pkg::REQ_TICK)
                    begin
                        ch_reg <= '0;
                        if (!req.dt[31])
                        begin
                            flag_reg  <= 1'b1;
                            accum_reg <= acc_clamped;
                            st_reg    <= S_CHECK;
                        end
                        else
                        begin
                            st_reg <= S_OUT_RD;
                        end
                    end
                end
                S_CHECK:
                begin
                    ch_reg <= '0;
                    if (regs.step_size != '0 && accum_reg > regs.step_size)
                    begin
                        st_reg <= S_RD;
                    end
                    else
                    begin
                        st_reg <= S_OUT_RD;
                    end
                end
                S_RD:
                begin
                    st_reg <= S_ERR;
                end
                S_ERR:
                begin
                    cur_reg <= state_rd_reg;
                    gl_reg  <= goal_rd_reg;
                    err_reg <= diff;
                    if (ang)
                    begin
                        mod_reg     <= diff[32] ? (34'(diff) + mptu_pkg::WRAP_OFS)
                                                : 34'(diff);
                        k_reg       <= mptu_pkg::WRAP_TOP;
                        wrap_ns_reg <= 1'b0;
                        st_reg      <= S_WRAP;
                    end
                    else
                    begin
                        st_reg <= S_MAG;
                    end
                end
                S_WRAP:
                begin
                    mod_reg <= mod_new;
                    k_reg   <= k_reg - 1'b1;
                    if (k_reg == '0)
                    begin
                        if (wrap_ns_reg)
                        begin
                            ns_reg <= mod_new[31:0];
                            st_reg <= S_WRITE;
                        end
                        else
                        begin
                            err_reg <= (mod_new >= mptu_pkg::DEG180)
                                     ? 33'(mod_new - mptu_pkg::DEG360) : 33'(mod_new);
                            st_reg  <= S_MAG;
                        end
                    end
                end
                S_MAG:
                begin
                    st_reg <= moving ? S_MUL : S_NEXT;
                end
                S_MUL:
                begin
                    prod_reg <= err_reg * $signed({1'b0, regs.gain[ch_reg]});
                    st_reg   <= S_PSAT;
                end
                S_PSAT:
                begin
                    if (p_sh > 42'sh10000000000)
                    begin
                        p_reg <= 42'sh10000000000;
                    end
                    else if (p_sh < -42'sh10000000000)
                    begin
                        p_reg <= -42'sh10000000000;
                    end
                    else
                    begin
                        p_reg <= p_sh;
                    end
                    st_reg <= S_MULL;
                end
                S_MULL:
                begin
                    lo_reg <= p_reg[23:0] * regs.step_size;
                    st_reg <= S_MULH;
                end
                S_MULH:
                begin
                    hi_reg <= $signed(p_reg[41:24]) * $signed({1'b0, regs.step_size});
                    st_reg <= S_SUM;
                end
                S_SUM:
                begin
                    flag_reg <= 1'b0;
                    if (ang)
                    begin
                        mod_reg     <= ns_sat[31] ? (34'(ns_sat) + mptu_pkg::WRAP_OFS)
                                                  : 34'(ns_sat);
                        k_reg       <= mptu_pkg::WRAP_TOP;
                        wrap_ns_reg <= 1'b1;
                        st_reg      <= S_WRAP;
                    end
                    else
                    begin
                        ns_reg <= ns_sat;
                        st_reg <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    st_reg <= S_NEXT;
                end
                S_NEXT:
                begin
                    if (last_ch)
                    begin
                        accum_reg <= accum_reg - regs.step_size;
                        st_reg    <= S_CHECK;
                    end
                    else
                    begin
                        ch_reg <= ch_reg + 1'b1;
                        st_reg <= S_RD;
                    end
                end
                S_OUT_RD:
                begin
                    st_reg <= S_OUT_LD;
                end
                S_OUT_LD:
                begin
                    out_valid_reg <= 1'b1;
                    out_ch_reg    <= ch_reg;
                    out_val_reg   <= state_rd_reg;
                    out_last_reg  <= last_ch;
                    st_reg        <= S_OUT_WAIT;
                end
                S_OUT_WAIT:
                begin
                    if (rsp.ready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (out_last_reg)
                        begin
                            ch_reg <= '0;
                            st_reg <= S_IDLE;
                        end
                        else
                        begin
                            ch_reg <= ch_reg + 1'b1;
                            st_reg <= S_OUT_RD;
                        end
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[src/mptu_checker.sv]
// Port-level checker for the tracker and its bind
`default_nettype none
`include "assert_macros.svh"
module mptu_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic out_last,
    input wire logic [1:0] out_channel,
    input wire logic [31:0] out_state
);
    // a stalled result holds
    `CHK_NEXT(a_hold, out_valid && !out_ready,
              out_valid && $stable(out_state) && $stable(out_channel))
    // no new request while a result is pending
    `CHK_NOW(a_excl, in_valid && in_ready, !out_valid)
    // the final result of a tick frees the request side
    `CHK_NEXT(a_free, out_valid && out_ready && out_last, in_ready)
    // between results of one tick the request side stays closed
    `CHK_NEXT(a_busy, out_valid && out_ready && !out_last, !out_valid && !in_ready)
endmodule

bind multichannel_proportional_tracker_unit mptu_checker u_mptu_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready), .out_last(rsp.last),
    .out_channel(rsp.out_channel), .out_state(rsp.state_value)
);
`default_nettype wire

[tb/sv/tb_top.sv]
// Testbench for the proportional tracker: directed and random requests, scoreboard
`default_nettype none
module tb_top;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam longint ANG360 = 64'd23592960;
    localparam longint ANG180 = 64'd11796480;
    localparam longint PROD_LIM = 64'd1 << 40;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [1:0]  ch;
        logic [31:0] val;
        logic        reached;
        logic        last;
    } track_result_t;

    class tracker_scoreboard;
        longint step, maxac, eps;
        logic [3:0] amask;
        longint gain[4];
        longint accum;
        int goal[4];
        int st[4];
        bit reached;
        track_result_t awaited_q[$];
        int errors;

        function new();
            step = 1092;
            maxac = 6554;
            eps = 1;
            amask = '0;
            foreach (gain[i]) gain[i] = 256;
            foreach (goal[i]) goal[i] = 0;
            foreach (st[i]) st[i] = 0;
            accum = 0;
            reached = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [mptu_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                mptu_pkg::CFG_STEP:  step = longint'(data[20:0]);
                mptu_pkg::CFG_MAXAC: maxac = longint'(data[20:0]);
                mptu_pkg::CFG_EPS:   eps = longint'(data[15:0]);
                mptu_pkg::CFG_ANGLE: amask = data[3:0];
                mptu_pkg::CFG_GAIN0: gain[0] = longint'(data[15:0]);
                mptu_pkg::CFG_GAIN1: gain[1] = longint'(data[15:0]);
                mptu_pkg::CFG_GAIN2: gain[2] = longint'(data[15:0]);
                mptu_pkg::CFG_GAIN3: gain[3] = longint'(data[15:0]);
                default: ;
            endcase
        endfunction

        function longint wrap_deg(longint x);
            longint r;
            r = x % ANG360;
            if (r < 0) r += ANG360;
            return r;
        endfunction

        function void run_substep();
            longint err, mag, p, d, ns;
            for (int i = 0; i < mptu_pkg::NUM_CHANNELS; i++) begin
                err = longint'(st[i]) - longint'(goal[i]);
                if (amask[i]) begin
                    err = wrap_deg(err);
                    if (err >= ANG180) err -= ANG360;
                end
                mag = (err < 0) ? -err : err;
                if (mag > eps) begin
                    p = (err * gain[i]) >>> 8;
                    if (p > PROD_LIM) p = PROD_LIM;
                    if (p < -PROD_LIM) p = -PROD_LIM;
                    d = (p * step) >>> 16;
                    ns = longint'(st[i]) - d;
                    if (ns > 64'sd2147483647) ns = 64'sd2147483647;
                    if (ns < -64'sd2147483648) ns = -64'sd2147483648;
                    if (amask[i]) ns = wrap_deg(ns);
                    st[i] = int'(ns);
                    reached = 0;
                end
                else
                    st[i] = goal[i];
            end
        endfunction

        function void note_request(logic [1:0] kind, logic [1:0] ch, int val, int dt);
            track_result_t r;
            if (kind == mptu_pkg::REQ_GOAL) goal[ch] = val;
            else if (kind == mptu_pkg::REQ_STATE) st[ch] = val;
            else if (kind == mptu_pkg::REQ_TICK) begin
                if (dt >= 0) begin
                    reached = 1;
                    accum += longint'(dt);
                    if (accum > maxac) accum = maxac;
                    if (step != 0)
                        while (accum > step) begin
                            run_substep();
                            accum -= step;
                        end
                end
                for (int i = 0; i < mptu_pkg::NUM_CHANNELS; i++) begin
                    r.ch = i[1:0];
                    r.val = st[i];
                    r.reached = reached;
                    r.last = (i == mptu_pkg::NUM_CHANNELS - 1);
                    awaited_q.push_back(r);
                end
            end
        endfunction

        function void check_result(track_result_t got);
            track_result_t e;
            if (awaited_q.size() == 0) begin
                $display("%0t: unexpected result ch %0d value %0d", $time, got.ch,
                         $signed(got.val));
                errors++;
                return;
            end
            e = awaited_q.pop_front();
            if (got.ch !== e.ch) begin
                $display("%0t: out_channel expected %0d actual %0d", $time, e.ch, got.ch);
                errors++;
            end
            if (got.val !== e.val) begin
                $display("%0t: state_value ch %0d expected %0d actual %0d", $time, e.ch,
                         $signed(e.val), $signed(got.val));
                errors++;
            end
            if (got.reached !== e.reached) begin
                $display("%0t: goal_reached expected %0b actual %0b", $time, e.reached,
                         got.reached);
                errors++;
            end
            if (got.last !== e.last) begin
                $display("%0t: last expected %0b actual %0b", $time, e.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    mptu_cfg_if cfg_ch();
    mptu_in_if  in_ch();
    mptu_out_if out_ch();

    multichannel_proportional_tracker_unit uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_ch),
        .req(in_ch),
        .rsp(out_ch)
    );

    tracker_scoreboard sb = new();
    bit quiet;
    bit hold_trigger;
    bit hold_used;
    int hold_cnt;
    int cycles;
    track_result_t seen;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side: random back-pressure plus one long hold-off
    initial
    begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_cnt > 0) begin
                hold_cnt--;
                out_ch.ready <= 1'b0;
            end
            else if (hold_trigger && !hold_used) begin
                hold_used = 1;
                hold_cnt = 400;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 31);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready) begin
            seen.ch = out_ch.out_channel;
            seen.val = out_ch.state_value;
            seen.reached = out_ch.goal_reached;
            seen.last = out_ch.last;
            sb.check_result(seen);
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_request(logic [1:0] kind, logic [1:0] ch, int val, int dt);
        if (!quiet && $urandom_range(0, 99) < 31) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        in_ch.req_type <= kind;
        in_ch.channel <= ch;
        in_ch.value <= val;
        in_ch.dt <= dt;
        in_ch.valid <= 1'b1;
        do @(posedge clk); while (!in_ch.ready);
        sb.note_request(kind, ch, val, dt);
        @(negedge clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.awaited_q.size() != 0) @(posedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(logic [mptu_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
        cfg_ch.index <= idx;
        cfg_ch.data <= data;
        cfg_ch.valid <= 1'b1;
        do @(posedge clk); while (!cfg_ch.ready);
        sb.set_reg(idx, data);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic write_all(int stp, int mx, int ep, int am, int g0, int g1, int g2, int g3);
        logic [31:0] junk;
        junk = $urandom & 32'hFFE0_0000;
        write_reg(mptu_pkg::CFG_STEP, junk | stp);
        write_reg(mptu_pkg::CFG_MAXAC, ($urandom & 32'hFFE0_0000) | mx);
        write_reg(mptu_pkg::CFG_EPS, ($urandom & 32'hFFFF_0000) | ep);
        write_reg(mptu_pkg::CFG_ANGLE, ($urandom & 32'hFFFF_FFF0) | am);
        write_reg(mptu_pkg::CFG_GAIN0, ($urandom & 32'hFFFF_0000) | g0);
        write_reg(mptu_pkg::CFG_GAIN1, ($urandom & 32'hFFFF_0000) | g1);
        write_reg(mptu_pkg::CFG_GAIN2, ($urandom & 32'hFFFF_0000) | g2);
        write_reg(mptu_pkg::CFG_GAIN3, ($urandom & 32'hFFFF_0000) | g3);
    endtask

    function automatic int pick_value();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return int'($urandom_range(0, 2097152)) - 1048576;
            2: return int'($urandom_range(0, 23592959));
            3: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    function automatic int pick_dt();
        int span;
        span = int'(sb.maxac + sb.step);
        case ($urandom_range(0, 9))
            0: return -int'($urandom_range(1, 32'h7FFF_FFFF));
            1: return $urandom;
            2: return 32'sh7FFF_FFFF;
            default: return int'($urandom_range(0, span));
        endcase
    endfunction

    function automatic int pick_gain();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 65535;
            default: return $urandom_range(1, 1024);
        endcase
    endfunction

    task automatic random_phase(int count);
        int k;
        for (int n = 0; n < count; n++) begin
            k = $urandom_range(0, 99);
            if (k < 38)
                send_request(mptu_pkg::REQ_TICK, 2'($urandom), pick_value(), pick_dt());
            else if (k < 68)
                send_request(mptu_pkg::REQ_GOAL, 2'($urandom), pick_value(), $urandom);
            else if (k < 94)
                send_request(mptu_pkg::REQ_STATE, 2'($urandom), pick_value(), $urandom);
            else
                send_request(REQ_UNUSED, 2'($urandom), $urandom, $urandom);
        end
    endtask

    initial
    begin
        int stp, mx, ratio;
        rst_n = 1'b0;
        quiet = 0;
        in_ch.valid = 1'b0;
        in_ch.req_type = mptu_pkg::REQ_TICK;
        in_ch.channel = '0;
        in_ch.value = '0;
        in_ch.dt = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = mptu_pkg::CFG_STEP;
        cfg_ch.data = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset settings, then extremes and angle wrap
        send_request(mptu_pkg::REQ_TICK, 2'd0, 0, 0);
        send_request(mptu_pkg::REQ_GOAL, 2'd0, 32'sh0001_0000, 0);
        send_request(mptu_pkg::REQ_GOAL, 2'd1, 32'sh7FFF_FFFF, 0);
        send_request(mptu_pkg::REQ_STATE, 2'd2, 32'sh8000_0000, 0);
        send_request(mptu_pkg::REQ_GOAL, 2'd3, 1, 0);
        send_request(mptu_pkg::REQ_TICK, 2'd0, 0, 32'sh7FFF_FFFF);
        send_request(mptu_pkg::REQ_TICK, 2'd0, 0, -1);
        send_request(mptu_pkg::REQ_TICK, 2'd0, 0, 32'sh8000_0000);
        send_request(REQ_UNUSED, 2'd3, 32'shFFFF_FFFF, 32'shFFFF_FFFF);
        send_request(mptu_pkg::REQ_TICK, 2'd0, 0, 500);
        drain();
        write_all(65536, 1048576, 65535, 4'hF, 65535, 0, 65535, 256);
        send_request(mptu_pkg::REQ_GOAL, 2'd0, 10 << 16, 0);
        send_request(mptu_pkg::REQ_STATE, 2'd0, 350 << 16, 0);
        send_request(mptu_pkg::REQ_GOAL, 2'd1, 180 << 16, 0);
        send_request(mptu_pkg::REQ_STATE, 2'd2, 32'sh8000_0000, 0);
        send_request(mptu_pkg::REQ_STATE, 2'd3, 32'sh7FFF_FFFF, 0);
        send_request(mptu_pkg::REQ_TICK, 2'd0, 0, 32'sh7FFF_FFFF);
        send_request(mptu_pkg::REQ_TICK, 2'd0, 0, 65536);
        drain();
        // zero step: accumulator only
        write_all(0, 1048576, 0, 4'h5, 1, 2, 3, 4);
        send_request(mptu_pkg::REQ_TICK, 2'd0, 0, 32'sh7FFF_FFFF);
        drain();
        write_all(1048576, 1048576, 1, 0, 256, 256, 256, 256);
        send_request(mptu_pkg::REQ_TICK, 2'd0, 0, 32'sh7FFF_FFFF);
        drain();
        write_all(1, 8, 0, 4'hA, 65535, 65535, 1, 1);
        send_request(mptu_pkg::REQ_STATE, 2'd1, 32'sh8000_0000, 0);
        send_request(mptu_pkg::REQ_TICK, 2'd0, 0, 32'sh7FFF_FFFF);
        drain();

        // random phases with a new setting each
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: stp = 1;
                1: stp = $urandom_range(64, 65536);
                2: stp = $urandom_range(0, 1) ? 2097151 : 1048576;
                default: stp = $urandom_range(0, 5) == 0 ? 0 : $urandom_range(500, 4000);
            endcase
            ratio = $urandom_range(1, 8);
            mx = (stp == 0) ? $urandom_range(1, 2097151) : stp * ratio;
            if (mx > 2097151 || mx < 1) mx = 2097151;
            write_all(stp, mx, $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                      : $urandom_range(0, 16), $urandom_range(0, 15),
                      pick_gain(), pick_gain(), pick_gain(), pick_gain());
            quiet = (ph == 2);
            if (ph == 5) hold_trigger = 1;
            random_phase(45);
            quiet = 0;
            drain();
        end

        drain();
        repeat (50) @(posedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire

[filelist.f]
+incdir+src
src/mptu_pkg.sv
src/mptu_if.sv
src/mptu_cfg.sv
src/multichannel_proportional_tracker_unit.sv
src/mptu_checker.sv
tb/sv/tb_top.sv
